// ===== hw/rtl/bps_pkg.sv =====
package bps_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int QUOT_BITS      = 10;
	localparam int STEP_BITS      = $clog2(QUOT_BITS);
	localparam int SPAN_BITS      = 16;
	localparam int NUM_BITS       = SPAN_BITS + QUOT_BITS - 1;
	localparam int ADDR_BITS      = 4;

	localparam logic        OP_MESSAGE = 1'b0;
	localparam logic        OP_LOAD    = 1'b1;
	localparam logic [3:0]  MIN_LENGTH = 4'd2;

	localparam logic [31:0] MIRROR_BASE = 32'd450;
	localparam logic [9:0]  OUT_CENTER  = 10'd500;
	localparam logic [9:0]  POS_MAX     = 10'd999;

	localparam logic [1:0]  REG_MIRROR = 2'd0;
	localparam logic [1:0]  REG_MIN    = 2'd1;
	localparam logic [1:0]  REG_CENTER = 2'd2;
	localparam logic [1:0]  REG_MAX    = 2'd3;

	localparam logic [SPAN_BITS-1:0] MIN_RESET    = 16'd0;
	localparam logic [SPAN_BITS-1:0] CENTER_RESET = 16'd225;
	localparam logic [SPAN_BITS-1:0] MAX_RESET    = 16'd450;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PREP,
		ST_DIV,
		ST_PUB
	} state_t;

endpackage

// ===== hw/rtl/bps_item_if.sv =====
interface bps_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [3:0]  payload_length;
	logic [7:0]  low_byte;
	logic [7:0]  high_byte;
	logic        fault_active;
	logic [14:0] holdoff_value;

	modport source (
		output valid, operation, payload_length, low_byte, high_byte,
			fault_active, holdoff_value,
		input  ready
	);
	modport sink (
		input  valid, operation, payload_length, low_byte, high_byte,
			fault_active, holdoff_value,
		output ready
	);
endinterface

// ===== hw/rtl/bps_result_if.sv =====
interface bps_result_if;
	logic        valid;
	logic        ready;
	logic        link_seen;
	logic        raw_updated;
	logic [31:0] raw_value;
	logic        position_updated;
	logic [9:0]  position;

	modport source (
		output valid, link_seen, raw_updated, raw_value, position_updated, position,
		input  ready
	);
	modport sink (
		input  valid, link_seen, raw_updated, raw_value, position_updated, position,
		output ready
	);
endinterface

// ===== hw/rtl/bucket_position_scaler_core.sv =====
// Sequence: a load item or short message passes ST_IDLE and ST_EVAL with no result.
// A message without scaling goes from ST_EVAL to ST_PUB, which registers its result
// once the result register is free; a scaled message first passes ST_PREP and ST_DIV,
// the restoring divider, one quotient bit per cycle. Items enter only in ST_IDLE.
// Reset (arst_n, async, active low) clears the hold-off count, the sequencer,
// the result valid and restores the span registers to 0 / 225 / 450.
module bucket_position_scaler_core
	import bps_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bps_item_if.sink             item,
	bps_result_if.source         result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam logic [32:0] CountMax = (33'd1 << (COUNT_BITS - 1)) - 33'd1;

	// configuration
	logic                 mirror_q;
	logic [SPAN_BITS-1:0] min_q, center_q, max_q;

	// sequencer
	state_t state_q, state_d;

	// latched item
	logic        op_q;
	logic [3:0]  len_q;
	logic [15:0] pos_in_q;
	logic        fault_q;
	logic [14:0] load_q;

	logic signed [COUNT_BITS-1:0] count_q;

	// divider
	logic [SPAN_BITS-1:0] diff_q, div_q;
	logic                 upper_q;
	logic [NUM_BITS-1:0]  rem_q, dsh_q;
	logic [QUOT_BITS-1:0] quot_q;
	logic [STEP_BITS-1:0] step_q;

	// pending result fields
	logic        link_q, raw_upd_q, pos_upd_q;
	logic [31:0] raw_q;

	// result register
	logic        res_valid_q;
	logic        res_link_q, res_raw_upd_q, res_pos_upd_q;
	logic [31:0] res_raw_q;
	logic [9:0]  res_pos_q;

	// control
	logic item_take, out_free, cfg_write, is_msg;

	// evaluation
	logic [32:0]           load_ext, load_sat;
	logic [COUNT_BITS-1:0] count_dec;
	logic                  report, span_ok;
	logic [31:0]           mirrored, clamp_hi;
	logic [SPAN_BITS-1:0]  clamped;
	logic                  trial_ok;
	logic [QUOT_BITS:0]    pos_sum;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign out_free  = !res_valid_q || result.ready;
	assign is_msg    = (op_q == OP_MESSAGE) && (len_q >= MIN_LENGTH);

	always_comb begin
		unique case (paddr[3:2])
			REG_MIRROR: prdata = {31'd0, mirror_q};
			REG_MIN:    prdata = {16'd0, min_q};
			REG_CENTER: prdata = {16'd0, center_q};
			REG_MAX:    prdata = {16'd0, max_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 1'b0;
			min_q    <= MIN_RESET;
			center_q <= CENTER_RESET;
			max_q    <= MAX_RESET;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_MIRROR: mirror_q <= pwdata[0];
				REG_MIN:    min_q    <= pwdata[SPAN_BITS-1:0];
				REG_CENTER: center_q <= pwdata[SPAN_BITS-1:0];
				REG_MAX:    max_q    <= pwdata[SPAN_BITS-1:0];
				default:    ;
			endcase
		end
	end

	// evaluation of the latched item
	always_comb begin
		load_ext  = {18'd0, load_q};
		load_sat  = (load_ext > CountMax) ? CountMax : load_ext;
		// count floors at -1
		count_dec = count_q[COUNT_BITS-1] ? count_q : count_q - 1'b1;
		report    = count_dec[COUNT_BITS-1] && !fault_q;
		mirrored  = mirror_q ? MIRROR_BASE - {16'd0, pos_in_q} : {16'd0, pos_in_q};
		span_ok   = (min_q < center_q) && (center_q < max_q);
		clamp_hi  = (mirrored > {16'd0, max_q}) ? {16'd0, max_q} : mirrored;
		clamped   = (clamp_hi < {16'd0, min_q}) ? min_q : clamp_hi[SPAN_BITS-1:0];
		trial_ok  = rem_q >= dsh_q;
		pos_sum   = {1'b0, quot_q} + (upper_q ? {1'b0, OUT_CENTER} : '0);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (item.valid) state_d = ST_EVAL;
			ST_EVAL: begin
				if (!is_msg)
					state_d = ST_IDLE;
				else if (report && span_ok)
					state_d = ST_PREP;
				else
					state_d = ST_PUB;
			end
			ST_PREP: state_d = ST_DIV;
			ST_DIV:  if (step_q == '0) state_d = ST_PUB;
			ST_PUB:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready = (state_q == ST_IDLE);
		item_take  = item.valid && item.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == ST_EVAL) begin
			if (op_q == OP_LOAD)
				count_q <= load_sat[COUNT_BITS-1:0];
			else if (is_msg)
				count_q <= report ? '0 : count_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			op_q     <= item.operation;
			len_q    <= item.payload_length;
			pos_in_q <= {item.high_byte, item.low_byte};
			fault_q  <= item.fault_active;
			load_q   <= item.holdoff_value;
		end
		unique case (state_q)
			ST_EVAL: begin
				link_q    <= 1'b1;
				raw_upd_q <= report;
				raw_q     <= report ? mirrored : 32'd0;
				pos_upd_q <= report && span_ok;
				quot_q    <= '0;
				if (clamped < center_q) begin
					diff_q  <= clamped - min_q;
					div_q   <= center_q - min_q;
					upper_q <= 1'b0;
				end else begin
					diff_q  <= clamped - center_q;
					div_q   <= max_q - center_q;
					upper_q <= 1'b1;
				end
			end
			ST_PREP: begin
				rem_q  <= NUM_BITS'(diff_q) * NUM_BITS'(OUT_CENTER);
				dsh_q  <= NUM_BITS'(div_q) << (QUOT_BITS - 1);
				step_q <= STEP_BITS'(QUOT_BITS - 1);
			end
			ST_DIV: begin
				if (trial_ok) rem_q <= rem_q - dsh_q;
				quot_q <= {quot_q[QUOT_BITS-2:0], trial_ok};
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q - 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_PUB && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUB && out_free) begin
			res_link_q    <= link_q;
			res_raw_upd_q <= raw_upd_q;
			res_raw_q     <= raw_q;
			res_pos_upd_q <= pos_upd_q;
			if (!pos_upd_q)
				res_pos_q <= '0;
			else if (pos_sum > {1'b0, POS_MAX})
				res_pos_q <= POS_MAX;
			else
				res_pos_q <= pos_sum[QUOT_BITS-1:0];
		end
	end

	assign result.valid            = res_valid_q;
	assign result.link_seen        = res_link_q;
	assign result.raw_updated      = res_raw_upd_q;
	assign result.raw_value        = res_raw_q;
	assign result.position_updated = res_pos_upd_q;
	assign result.position         = res_pos_q;

endmodule

// ===== dv/tb_bucket_position_scaler_core.sv =====
module tb_bucket_position_scaler_core;
	timeunit 1ns;
	timeprecision 1ps;
	import bps_pkg::*;

	localparam int     COUNT_W   = COUNT_BITS_DEF;
	localparam longint COUNT_TOP = (64'sd1 <<< (COUNT_W - 1)) - 1;
	localparam int     SETTLE    = 20;

	typedef struct {
		logic        op;
		logic [3:0]  len;
		logic [7:0]  lo_b;
		logic [7:0]  hi_b;
		logic        fault;
		logic [14:0] load;
	} frame_t;

	typedef struct packed {
		logic        link;
		logic        raw_upd;
		logic [31:0] raw;
		logic        pos_upd;
		logic [9:0]  pos;
	} reading_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	bps_item_if   frame_bus ();
	bps_result_if reading_bus ();

	bucket_position_scaler_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (frame_bus),
		.result  (reading_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	frame_t   frames_pending[$];
	reading_t readings_due[$];
	frame_t   on_bus;
	int       n_queued;
	int       n_accepted;
	int       mismatches;
	int       idle_pct = 22;

	// shadow of the block's calibration and hold-off count
	logic        cfg_mirror;
	logic [15:0] cfg_min;
	logic [15:0] cfg_center;
	logic [15:0] cfg_max;
	longint      hold_count;

	function automatic void note_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch: %s", $realtime, what);
	endfunction

	function automatic void predict_reading(frame_t f);
		reading_t    r;
		logic [31:0] v, c, q, lo32, mid32, hi32;
		lo32  = {16'd0, cfg_min};
		mid32 = {16'd0, cfg_center};
		hi32  = {16'd0, cfg_max};
		if (f.op == OP_LOAD) begin
			hold_count = (longint'(f.load) > COUNT_TOP) ? COUNT_TOP : longint'(f.load);
			return;
		end
		if (f.len < MIN_LENGTH)
			return;
		r = '0;
		r.link = 1'b1;
		if (hold_count > -1)
			hold_count--;
		if (hold_count < 0 && !f.fault) begin
			hold_count = 0;
			v = {16'd0, f.hi_b, f.lo_b};
			if (cfg_mirror)
				v = MIRROR_BASE - v;
			r.raw_upd = 1'b1;
			r.raw = v;
			if (lo32 < mid32 && mid32 < hi32) begin
				c = v;
				if (c > hi32) c = hi32;
				if (c < lo32) c = lo32;
				if (c < mid32)
					q = (c - lo32) * 32'(OUT_CENTER) / (mid32 - lo32);
				else
					q = (c - mid32) * 32'(OUT_CENTER) / (hi32 - mid32) + 32'(OUT_CENTER);
				if (q > 32'(POS_MAX))
					q = 32'(POS_MAX);
				r.pos_upd = 1'b1;
				r.pos = q[9:0];
			end
		end
		readings_due.push_back(r);
	endfunction

	function automatic void queue_frame(logic op, logic [3:0] len, logic [7:0] lo_b,
			logic [7:0] hi_b, logic fault, logic [14:0] load);
		frame_t f;
		f.op    = op;
		f.len   = len;
		f.lo_b  = lo_b;
		f.hi_b  = hi_b;
		f.fault = fault;
		f.load  = load;
		frames_pending.push_back(f);
		n_queued++;
	endfunction

	// bias positions toward the span corners; with mirroring aim at the mirrored value
	function automatic logic [15:0] aim_position();
		logic [15:0] target;
		case ($urandom_range(5))
			0: return 16'($urandom);
			1: target = cfg_min + 16'($urandom_range(6)) - 16'd3;
			2: target = cfg_center + 16'($urandom_range(6)) - 16'd3;
			3: target = cfg_max + 16'($urandom_range(6)) - 16'd3;
			4: return 16'($urandom_range(460));
			default: target = 16'($urandom_range(cfg_min, cfg_max));
		endcase
		if (cfg_mirror)
			target = MIRROR_BASE[15:0] - target;
		return target;
	endfunction

	function automatic void queue_position_frame();
		logic [15:0] p;
		p = aim_position();
		queue_frame(OP_MESSAGE, 4'($urandom_range(2, 8)), p[7:0], p[15:8],
			$urandom_range(9) == 0, 15'($urandom));
	endfunction

	function automatic void queue_load(logic [14:0] load);
		queue_frame(OP_LOAD, 4'($urandom_range(8)), 8'($urandom), 8'($urandom),
			1'($urandom), load);
	endfunction

	function automatic void fill_random(int n);
		int start, k;
		start = n_queued;
		while (n_queued - start < n) begin
			case ($urandom_range(19))
				0: queue_frame(OP_MESSAGE, 4'($urandom_range(1)), 8'($urandom),
					8'($urandom), 1'($urandom), 15'($urandom));
				1: begin
					// long hold-off, a few messages into it, then cut short
					queue_load(15'($urandom_range(32767)));
					repeat ($urandom_range(1, 3)) queue_position_frame();
					queue_load(15'($urandom_range(2)));
				end
				2, 3, 4: begin
					k = $urandom_range(3);
					queue_load(15'(k));
					repeat (k + 1) queue_position_frame();
				end
				default: queue_position_frame();
			endcase
		end
	endfunction

	task automatic reg_write(logic [1:0] idx, logic [15:0] val);
		logic [31:0] back, want;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BITS'({idx, 2'b00});
		pwdata  <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MIRROR: cfg_mirror = val[0];
			REG_MIN:    cfg_min    = val;
			REG_CENTER: cfg_center = val;
			REG_MAX:    cfg_max    = val;
		endcase
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		back = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		want = (idx == REG_MIRROR) ? {31'd0, val[0]} : {16'd0, val};
		if (back !== want)
			note_mismatch($sformatf("register %0d read back %0h, expected %0h", idx, back, want));
	endtask

	task automatic program_span(logic m, logic [15:0] lo, logic [15:0] mid, logic [15:0] hi);
		reg_write(REG_MIRROR, {15'd0, m});
		reg_write(REG_MIN, lo);
		reg_write(REG_CENTER, mid);
		reg_write(REG_MAX, hi);
	endtask

	task automatic wait_settled();
		while (n_accepted != n_queued || readings_due.size() != 0)
			@(posedge clk);
		// room for items that end without a reading
		repeat (SETTLE) @(posedge clk);
	endtask

	// frame source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_bus.valid <= 1'b0;
		end else begin
			if (frame_bus.valid && frame_bus.ready) begin
				predict_reading(on_bus);
				n_accepted++;
			end
			if (!frame_bus.valid || frame_bus.ready) begin
				if (frames_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
					on_bus = frames_pending.pop_front();
					frame_bus.valid          <= 1'b1;
					frame_bus.operation      <= on_bus.op;
					frame_bus.payload_length <= on_bus.len;
					frame_bus.low_byte       <= on_bus.lo_b;
					frame_bus.high_byte      <= on_bus.hi_b;
					frame_bus.fault_active   <= on_bus.fault;
					frame_bus.holdoff_value  <= on_bus.load;
				end else begin
					frame_bus.valid <= 1'b0;
				end
			end
		end
	end

	// reading sink and checker
	always @(posedge clk or negedge arst_n) begin : watch_readings
		reading_t want, got;
		if (!arst_n) begin
			reading_bus.ready <= 1'b0;
		end else begin
			if (reading_bus.valid && reading_bus.ready) begin
				got.link    = reading_bus.link_seen;
				got.raw_upd = reading_bus.raw_updated;
				got.raw     = reading_bus.raw_value;
				got.pos_upd = reading_bus.position_updated;
				got.pos     = reading_bus.position;
				if (readings_due.size() == 0) begin
					note_mismatch($sformatf("unexpected reading link=%0b raw=%0d pos=%0d",
						got.link, got.raw, got.pos));
				end else begin
					want = readings_due.pop_front();
					if (got.link !== want.link || got.raw_upd !== want.raw_upd ||
							got.raw !== want.raw || got.pos_upd !== want.pos_upd ||
							got.pos !== want.pos)
						note_mismatch($sformatf({"expected link=%0b raw_upd=%0b raw=%0d ",
							"pos_upd=%0b pos=%0d, got link=%0b raw_upd=%0b raw=%0d ",
							"pos_upd=%0b pos=%0d"},
							want.link, want.raw_upd, want.raw, want.pos_upd, want.pos,
							got.link, got.raw_upd, got.raw, got.pos_upd, got.pos));
				end
			end
			reading_bus.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	initial begin
		logic [15:0] lo_r, mid_r;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		cfg_mirror = 1'b0;
		cfg_min    = MIN_RESET;
		cfg_center = CENTER_RESET;
		cfg_max    = MAX_RESET;
		hold_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration 0/225/450
		queue_frame(OP_MESSAGE, 4'd0, 8'h12, 8'h34, 1'b0, 15'd0);
		queue_frame(OP_MESSAGE, 4'd1, 8'hff, 8'hff, 1'b0, 15'd0);
		queue_frame(OP_MESSAGE, 4'd2, 8'h00, 8'h00, 1'b0, 15'd0);
		queue_frame(OP_MESSAGE, 4'd8, 8'hff, 8'hff, 1'b0, 15'd0);
		queue_frame(OP_MESSAGE, 4'd7, 8'he1, 8'h00, 1'b0, 15'd0);
		queue_frame(OP_MESSAGE, 4'd4, 8'hc2, 8'h01, 1'b0, 15'd0);
		queue_frame(OP_MESSAGE, 4'd3, 8'd100, 8'h00, 1'b0, 15'd0);
		// hold-off of two; a short message must not count down
		queue_frame(OP_LOAD, 4'd0, 8'h00, 8'h00, 1'b0, 15'd2);
		queue_frame(OP_MESSAGE, 4'd1, 8'd50, 8'h00, 1'b0, 15'd0);
		repeat (3) queue_frame(OP_MESSAGE, 4'd2, 8'd50, 8'h00, 1'b0, 15'd0);
		// fault holds the count at its floor until it clears
		queue_frame(OP_LOAD, 4'd8, 8'hff, 8'hff, 1'b1, 15'd0);
		queue_frame(OP_MESSAGE, 4'd2, 8'd200, 8'h00, 1'b1, 15'd0);
		queue_frame(OP_MESSAGE, 4'd2, 8'd200, 8'h00, 1'b1, 15'd0);
		queue_frame(OP_MESSAGE, 4'd2, 8'd200, 8'h00, 1'b0, 15'd0);
		// largest hold-off, then dropped again
		queue_frame(OP_LOAD, 4'd2, 8'h00, 8'h00, 1'b0, 15'h7fff);
		queue_frame(OP_MESSAGE, 4'd2, 8'd10, 8'h00, 1'b0, 15'h7fff);
		queue_frame(OP_LOAD, 4'd2, 8'h00, 8'h00, 1'b0, 15'd0);
		queue_frame(OP_MESSAGE, 4'd5, 8'd10, 8'h00, 1'b0, 15'd0);
		wait_settled();

		// mirrored, including values past 450 that wrap
		program_span(1'b1, MIN_RESET, CENTER_RESET, MAX_RESET);
		queue_frame(OP_MESSAGE, 4'd2, 8'h00, 8'h00, 1'b0, 15'd0);
		queue_frame(OP_MESSAGE, 4'd2, 8'hc2, 8'h01, 1'b0, 15'd0);
		queue_frame(OP_MESSAGE, 4'd2, 8'hc3, 8'h01, 1'b0, 15'd0);
		queue_frame(OP_MESSAGE, 4'd2, 8'hff, 8'hff, 1'b0, 15'd0);
		fill_random(130);
		wait_settled();

		idle_pct = 0;
		program_span(1'b0, 16'd0, 16'd1, 16'hffff);
		fill_random(130);
		wait_settled();
		idle_pct = 22;

		program_span(1'b1, 16'hfffd, 16'hfffe, 16'hffff);
		fill_random(120);
		wait_settled();

		// inconsistent spans: raw only
		program_span(1'b0, 16'd500, 16'd500, 16'd1000);
		fill_random(90);
		wait_settled();

		program_span(1'b1, 16'd3000, 16'd1000, 16'd2000);
		fill_random(90);
		wait_settled();

		// sender pauses mid-phase until all readings are back
		program_span(1'b0, MIN_RESET, CENTER_RESET, MAX_RESET);
		fill_random(70);
		wait_settled();
		fill_random(70);
		wait_settled();

		repeat (3) begin
			lo_r  = 16'($urandom_range(60000));
			mid_r = lo_r + 16'($urandom_range(1, 2000));
			program_span(1'($urandom), lo_r, mid_r, mid_r + 16'($urandom_range(1, 3000)));
			fill_random(140);
			wait_settled();
		end

		program_span(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		fill_random(100);
		wait_settled();

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/bps_pkg.sv
hw/rtl/bps_item_if.sv
hw/rtl/bps_result_if.sv
hw/rtl/bucket_position_scaler_core.sv
dv/tb_bucket_position_scaler_core.sv
